// ===== rtl/core/twodo_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-wheel odometry package
// Shared widths, fixed-point constants, codes, state type and helper functions.
// ----------------------------------------------------------------------------
package twodo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int IT_W         = $clog2(CORDIC_STEPS);
    localparam int CW           = 51;
    localparam int ZW           = 35;
    localparam int DVD_W        = 78;
    localparam int DIV_CNT_W    = $clog2(DVD_W);
    localparam int MUL_W        = 34;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int IDX_W        = 4;

    localparam logic signed [33:0]   PI28     = 34'sd843314857;
    localparam logic signed [33:0]   TWOPI28  = 34'sd1686629713;
    localparam logic signed [ZW-1:0] HALFPI30 = 35'sd1686629713;
    localparam logic signed [ZW-1:0] PI30     = 35'sd3373259426;
    localparam logic signed [ZW-1:0] TWOPI30  = 35'sd6746518852;
    localparam logic signed [33:0]   GAIN30   = 34'sd652032874;

    localparam logic [23:0] LEFT_OFFSET_RST  = 24'd434176;
    localparam logic [23:0] RIGHT_OFFSET_RST = 24'd432144;
    localparam logic [23:0] SIDE_OFFSET_RST  = 24'd284688;
    localparam logic [23:0] DIST_PER_DEG_RST = 24'd475829;

    typedef enum logic [IDX_W-1:0] {
        CFG_LEFT_OFFSET   = 0,
        CFG_RIGHT_OFFSET  = 1,
        CFG_SIDE_OFFSET   = 2,
        CFG_WHEEL_DIST    = 3,
        CFG_SIDE_DIST     = 4,
        CFG_LEFT_REF      = 5,
        CFG_RIGHT_REF     = 6,
        CFG_HEADING_REF   = 7
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL_DR, S_MUL_DS, S_MUL_P, S_DIV_LOAD, S_DIV, S_TERM0, S_TERM,
        S_ADDREF, S_WRAP_TH, S_WRAP_DTH, S_MUL_SS, S_DSIDE, S_CPRE, S_CIT,
        S_RATIO_LOAD, S_RATIO, S_MUL_RX, S_MUL_SY, S_DX, S_MUL_RY, S_DY,
        S_Z0, S_Z1, S_Z2, S_ROUND, S_FINISH
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:    r = 35'sh3243F6A8;
            5'd1:    r = 35'sh1DAC6705;
            5'd2:    r = 35'sh0FADBAFC;
            5'd3:    r = 35'sh07F56EA6;
            5'd4:    r = 35'sh03FEAB76;
            5'd5:    r = 35'sh01FFD55B;
            5'd6:    r = 35'sh00FFFAAA;
            5'd7:    r = 35'sh007FFF55;
            5'd8:    r = 35'sh003FFFEA;
            5'd9:    r = 35'sh001FFFFD;
            5'd10:   r = 35'sh000FFFFF;
            5'd11:   r = 35'sh0007FFFF;
            5'd12:   r = 35'sh0003FFFF;
            5'd13:   r = 35'sh0001FFFF;
            5'd14:   r = 35'sh0000FFFF;
            5'd15:   r = 35'sh00007FFF;
            5'd16:   r = 35'sh00003FFF;
            5'd17:   r = 35'sh00001FFF;
            5'd18:   r = 35'sh00000FFF;
            5'd19:   r = 35'sh000007FF;
            5'd20:   r = 35'sh000003FF;
            5'd21:   r = 35'sh000001FF;
            5'd22:   r = 35'sh000000FF;
            5'd23:   r = 35'sh0000007F;
            5'd24:   r = 35'sh0000003F;
            5'd25:   r = 35'sh0000001F;
            5'd26:   r = 35'sh0000000F;
            5'd27:   r = 35'sh00000008;
            5'd28:   r = 35'sh00000004;
            5'd29:   r = 35'sh00000002;
            5'd30:   r = 35'sh00000001;
            default: r = 35'sh00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/twodo_if.sv =====
// ----------------------------------------------------------------------------
// Three-wheel odometry channels
// Valid/ready channels for encoder samples, pose results and register writes.
// ----------------------------------------------------------------------------
interface twodo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [31:0] side_count;

    modport source (output valid, output left_count, output right_count,
                    output side_count, input ready);
    modport sink (input valid, input left_count, input right_count,
                  input side_count, output ready);
endinterface

interface twodo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [30:0] heading;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading,
                  output ready);
endinterface

interface twodo_cfg_if;
    import twodo_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [31:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/three_wheel_odometry.sv =====
// ----------------------------------------------------------------------------
// Three-wheel arc odometry
// Tracks x, y and heading from left, right and side encoder samples.
// ----------------------------------------------------------------------------
// One sample is taken when the block is idle, and its pose is computed before
// the next sample is accepted. The heading division is skipped when the
// offsets sum to zero, and the half-angle sine and the arc ratio are skipped
// when the heading does not change. The work is done by a shared restoring
// divider that resolves one quotient bit per cycle over 78 bits, used once
// for the heading and once for the arc ratio, and by a shared CORDIC unit
// that runs 24 iterations for the half-angle sine and again for the final
// rotation, next to a single 34 by 34 bit multiplier. A finished pose waits
// in the output register while the next sample is accepted, and a new pose
// is held back until the previous one has been taken.
module three_wheel_odometry (
    input logic          clk,
    input logic          rst_n,
    twodo_cfg_if.sink    cfg,
    twodo_in_if.sink     sample,
    twodo_out_if.source  pose
);
    import twodo_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [IT_W-1:0]      it_reg, it_next;
    logic   cmode_reg, cmode_next;
    logic   dmode_reg, dmode_next;

    logic [23:0]        left_off_reg, left_off_next;
    logic [23:0]        right_off_reg, right_off_next;
    logic [23:0]        side_off_reg, side_off_next;
    logic [23:0]        wheel_k_reg, wheel_k_next;
    logic [23:0]        side_k_reg, side_k_next;
    logic signed [31:0] left_ref_reg, left_ref_next;
    logic signed [31:0] right_ref_reg, right_ref_next;
    logic signed [30:0] head_ref_reg, head_ref_next;

    logic signed [31:0] prev_right_reg, prev_right_next;
    logic signed [31:0] prev_side_reg, prev_side_next;
    logic signed [31:0] x_accum_reg, x_accum_next;
    logic signed [31:0] y_accum_reg, y_accum_next;
    logic signed [30:0] heading_now_reg, heading_now_next;

    logic signed [31:0]       cl_reg, cl_next, cr_reg, cr_next, cs_reg, cs_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [31:0]       dright_reg, dright_next, dside_reg, dside_next;
    logic signed [33:0]       wv_reg, wv_next;
    logic signed [30:0]       theta_reg, theta_next, dth_reg, dth_next;
    logic signed [CW-1:0]     a_reg, a_next, b_reg, b_next;
    logic signed [ZW-1:0]     z_reg, z_next;
    logic [DVD_W-1:0]         dvd_reg, dvd_next;
    logic [30:0]              rem_reg, rem_next, dvs_reg, dvs_next;
    logic [30:0]              qmod_reg, qmod_next, qsat_reg, qsat_next;
    logic                     neg_reg, neg_next;
    logic signed [31:0]       sy_reg, sy_next;
    logic signed [30:0]       ratio_reg, ratio_next;
    logic signed [33:0]       t1_reg, t1_next;
    logic signed [31:0]       dx_reg, dx_next, dy_reg, dy_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [33:0]       d_right, d_side, d_lr;
    logic signed [31:0]       rnd8, dside_adj, rnd16a, rnd16b;
    logic [PROD_W-1:0]        abs_p;
    logic [24:0]              offs_sum;
    logic [31:0]              div_t, q2, v1;
    logic                     div_ge;
    logic [31:0]              sy_abs;
    logic [30:0]              dth_abs, ratio_mag;
    logic signed [CW-1:0]     c_da, c_db;
    logic signed [ZW-1:0]     c_atan, zsum;
    logic signed [33:0]       rnd28;
    logic signed [71:0]       rnd29;
    logic                     out_free;

    assign cfg.ready    = 1'b1;
    assign sample.ready = (state_reg == S_IDLE);
    assign pose.valid   = out_valid_reg;
    assign pose.pos_x   = x_accum_reg;
    assign pose.pos_y   = y_accum_reg;
    assign pose.heading = heading_now_reg;

    assign prod_next = mul_a * mul_b;
    assign d_right   = 34'(cr_reg) - 34'(prev_right_reg);
    assign d_side    = 34'(cs_reg) - 34'(prev_side_reg);
    assign d_lr      = (34'(cl_reg) - 34'(left_ref_reg)) - (34'(cr_reg) - 34'(right_ref_reg));
    assign rnd8      = sat32(72'((prod_reg + 68'sd128) >>> 8));
    assign abs_p     = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign offs_sum  = 25'(left_off_reg) + 25'(right_off_reg);
    assign div_t     = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_ge    = (div_t >= {1'b0, dvs_reg});
    assign q2        = {qmod_reg, div_ge};
    assign v1        = {1'b0, qmod_reg} + 32'(rem_reg != 31'd0);
    assign dside_adj = sat32(72'(dside_reg) - 72'((prod_reg + 68'sd134217728) >>> 28));
    assign sy_abs    = b_reg[CW-1] ? 32'(-b_reg) : 32'(b_reg);
    assign dth_abs   = dth_reg[30] ? 31'(-(32'(dth_reg))) : 31'(dth_reg);
    assign ratio_mag = (qsat_reg > 31'd536870912) ? 31'd536870912 : qsat_reg;
    assign c_da      = b_reg >>> it_reg;
    assign c_db      = a_reg >>> it_reg;
    assign c_atan    = atan_q30(5'(it_reg));
    assign rnd28     = 34'((prod_reg + 68'sd134217728) >>> 28);
    assign rnd29     = 72'((prod_reg + 68'sd268435456) >>> 29);
    assign zsum      = (ZW'(heading_now_reg) <<< 2) + (ZW'(dth_reg) <<< 1);
    assign rnd16a    = sat32(72'((a_reg + CW'(32768)) >>> 16));
    assign rnd16b    = sat32(72'((b_reg + CW'(32768)) >>> 16));
    assign out_free  = !out_valid_reg || pose.ready;

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        cnt_next         = cnt_reg;
        it_next          = it_reg;
        cmode_next       = cmode_reg;
        dmode_next       = dmode_reg;
        left_off_next    = left_off_reg;
        right_off_next   = right_off_reg;
        side_off_next    = side_off_reg;
        wheel_k_next     = wheel_k_reg;
        side_k_next      = side_k_reg;
        left_ref_next    = left_ref_reg;
        right_ref_next   = right_ref_reg;
        head_ref_next    = head_ref_reg;
        prev_right_next  = prev_right_reg;
        prev_side_next   = prev_side_reg;
        x_accum_next     = x_accum_reg;
        y_accum_next     = y_accum_reg;
        heading_now_next = heading_now_reg;
        cl_next          = cl_reg;
        cr_next          = cr_reg;
        cs_next          = cs_reg;
        dright_next      = dright_reg;
        dside_next       = dside_reg;
        wv_next          = wv_reg;
        theta_next       = theta_reg;
        dth_next         = dth_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        z_next           = z_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        dvs_next         = dvs_reg;
        qmod_next        = qmod_reg;
        qsat_next        = qsat_reg;
        neg_next         = neg_reg;
        sy_next          = sy_reg;
        ratio_next       = ratio_reg;
        t1_next          = t1_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        mul_a            = '0;
        mul_b            = '0;

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LEFT_OFFSET:  left_off_next  = cfg.data[23:0];
                CFG_RIGHT_OFFSET: right_off_next = cfg.data[23:0];
                CFG_SIDE_OFFSET:  side_off_next  = cfg.data[23:0];
                CFG_WHEEL_DIST:   wheel_k_next   = cfg.data[23:0];
                CFG_SIDE_DIST:    side_k_next    = cfg.data[23:0];
                CFG_LEFT_REF:     left_ref_next  = cfg.data;
                CFG_RIGHT_REF:    right_ref_next = cfg.data;
                CFG_HEADING_REF:  head_ref_next  = cfg.data[30:0];
                default:          ;
            endcase
        end

        if (out_valid_reg && pose.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    cl_next    = sample.left_count;
                    cr_next    = sample.right_count;
                    cs_next    = sample.side_count;
                    state_next = S_MUL_DR;
                end
            end
            S_MUL_DR:
            begin
                mul_a      = d_right;
                mul_b      = MUL_W'(wheel_k_reg);
                state_next = S_MUL_DS;
            end
            S_MUL_DS:
            begin
                dright_next = rnd8;
                mul_a       = d_side;
                mul_b       = MUL_W'(side_k_reg);
                state_next  = S_MUL_P;
            end
            S_MUL_P:
            begin
                dside_next = rnd8;
                mul_a      = d_lr;
                mul_b      = MUL_W'(wheel_k_reg);
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD:
            begin
                if (offs_sum == 25'd0)
                begin
                    wv_next    = '0;
                    state_next = S_ADDREF;
                end else begin
                    dvd_next   = {abs_p[57:0], 20'd0};
                    dvs_next   = 31'(offs_sum);
                    neg_next   = prod_reg[PROD_W-1];
                    rem_next   = '0;
                    qmod_next  = '0;
                    qsat_next  = '0;
                    cnt_next   = '0;
                    dmode_next = 1'b0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = div_ge ? 31'(div_t - {1'b0, dvs_reg}) : div_t[30:0];
                dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                qmod_next = (q2 >= 32'(TWOPI28)) ? 31'(q2 - 32'(TWOPI28)) : q2[30:0];
                qsat_next = qsat_reg[30] ? '1 : {qsat_reg[29:0], div_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    state_next = dmode_reg ? S_RATIO : S_TERM0;
                end
            end
            S_TERM0:
            begin
                if (neg_reg)
                begin
                    qmod_next = (v1 == 32'(TWOPI28)) ? '0 : v1[30:0];
                end
                state_next = S_TERM;
            end
            S_TERM:
            begin
                if (neg_reg && qmod_reg != 31'd0)
                begin
                    wv_next = TWOPI28 - 34'(qmod_reg);
                end else begin
                    wv_next = 34'(qmod_reg);
                end
                state_next = S_ADDREF;
            end
            S_ADDREF:
            begin
                wv_next    = wv_reg + 34'(head_ref_reg);
                state_next = S_WRAP_TH;
            end
            S_WRAP_TH:
            begin
                if (wv_reg >= PI28)
                begin
                    wv_next = wv_reg - TWOPI28;
                end else if (wv_reg < -PI28)
                begin
                    wv_next = wv_reg + TWOPI28;
                end else begin
                    theta_next = wv_reg[30:0];
                    wv_next    = wv_reg - 34'(heading_now_reg);
                    state_next = S_WRAP_DTH;
                end
            end
            S_WRAP_DTH:
            begin
                if (wv_reg >= PI28)
                begin
                    wv_next = wv_reg - TWOPI28;
                end else if (wv_reg < -PI28)
                begin
                    wv_next = wv_reg + TWOPI28;
                end else begin
                    dth_next   = wv_reg[30:0];
                    state_next = S_MUL_SS;
                end
            end
            S_MUL_SS:
            begin
                mul_a      = MUL_W'(side_off_reg);
                mul_b      = MUL_W'(dth_reg);
                state_next = S_DSIDE;
            end
            S_DSIDE:
            begin
                dside_next = dside_adj;
                if (dth_reg == 31'sd0)
                begin
                    dx_next    = dside_adj;
                    dy_next    = dright_reg;
                    state_next = S_Z0;
                end else begin
                    a_next     = CW'(GAIN30);
                    b_next     = '0;
                    z_next     = ZW'(dth_reg) <<< 1;
                    cmode_next = 1'b0;
                    state_next = S_CPRE;
                end
            end
            S_CPRE:
            begin
                if (z_reg > HALFPI30)
                begin
                    a_next = -b_reg;
                    b_next = a_reg;
                    z_next = z_reg - HALFPI30;
                end else if (z_reg < -HALFPI30)
                begin
                    a_next = b_reg;
                    b_next = -a_reg;
                    z_next = z_reg + HALFPI30;
                end
                it_next    = '0;
                state_next = S_CIT;
            end
            S_CIT:
            begin
                if (!z_reg[ZW-1])
                begin
                    a_next = a_reg - c_da;
                    b_next = b_reg + c_db;
                    z_next = z_reg - c_atan;
                end else begin
                    a_next = a_reg + c_da;
                    b_next = b_reg - c_db;
                    z_next = z_reg + c_atan;
                end
                it_next = it_reg + 1'b1;
                if (it_reg == IT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = cmode_reg ? S_ROUND : S_RATIO_LOAD;
                end
            end
            S_RATIO_LOAD:
            begin
                sy_next    = b_reg[31:0];
                dvd_next   = {19'd0, sy_abs, 27'd0};
                dvs_next   = dth_abs;
                neg_next   = b_reg[CW-1] ^ dth_reg[30];
                rem_next   = '0;
                qmod_next  = '0;
                qsat_next  = '0;
                cnt_next   = '0;
                dmode_next = 1'b1;
                state_next = S_DIV;
            end
            S_RATIO:
            begin
                ratio_next = neg_reg ? -$signed(ratio_mag) : $signed(ratio_mag);
                state_next = S_MUL_RX;
            end
            S_MUL_RX:
            begin
                mul_a      = MUL_W'(ratio_reg);
                mul_b      = MUL_W'(dside_reg);
                state_next = S_MUL_SY;
            end
            S_MUL_SY:
            begin
                t1_next    = rnd28;
                mul_a      = MUL_W'(sy_reg);
                mul_b      = MUL_W'(side_off_reg);
                state_next = S_DX;
            end
            S_DX:
            begin
                dx_next    = sat32(72'(t1_reg) + rnd29);
                mul_a      = MUL_W'(ratio_reg);
                mul_b      = MUL_W'(dright_reg);
                state_next = S_MUL_RY;
            end
            S_MUL_RY:
            begin
                t1_next    = rnd28;
                mul_a      = MUL_W'(sy_reg);
                mul_b      = MUL_W'(right_off_reg);
                state_next = S_DY;
            end
            S_DY:
            begin
                dy_next    = sat32(72'(t1_reg) + rnd29);
                state_next = S_Z0;
            end
            S_Z0:
            begin
                z_next     = -zsum;
                mul_a      = MUL_W'(dx_reg);
                mul_b      = GAIN30;
                state_next = S_Z1;
            end
            S_Z1:
            begin
                if (z_reg >= PI30)
                begin
                    z_next = z_reg - TWOPI30;
                end else if (z_reg < -PI30)
                begin
                    z_next = z_reg + TWOPI30;
                end
                a_next     = CW'(prod_reg >>> 14);
                mul_a      = MUL_W'(dy_reg);
                mul_b      = GAIN30;
                state_next = S_Z2;
            end
            S_Z2:
            begin
                b_next     = CW'(prod_reg >>> 14);
                cmode_next = 1'b1;
                state_next = S_CPRE;
            end
            S_ROUND:
            begin
                dx_next    = rnd16a;
                dy_next    = rnd16b;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    x_accum_next     = x_accum_reg - dx_reg;
                    y_accum_next     = y_accum_reg + dy_reg;
                    heading_now_next = theta_reg;
                    prev_right_next  = cr_reg;
                    prev_side_next   = cs_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            it_reg          <= '0;
            cmode_reg       <= 1'b0;
            dmode_reg       <= 1'b0;
            left_off_reg    <= LEFT_OFFSET_RST;
            right_off_reg   <= RIGHT_OFFSET_RST;
            side_off_reg    <= SIDE_OFFSET_RST;
            wheel_k_reg     <= DIST_PER_DEG_RST;
            side_k_reg      <= DIST_PER_DEG_RST;
            left_ref_reg    <= '0;
            right_ref_reg   <= '0;
            head_ref_reg    <= '0;
            prev_right_reg  <= '0;
            prev_side_reg   <= '0;
            x_accum_reg     <= '0;
            y_accum_reg     <= '0;
            heading_now_reg <= '0;
        end else begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            cnt_reg         <= cnt_next;
            it_reg          <= it_next;
            cmode_reg       <= cmode_next;
            dmode_reg       <= dmode_next;
            left_off_reg    <= left_off_next;
            right_off_reg   <= right_off_next;
            side_off_reg    <= side_off_next;
            wheel_k_reg     <= wheel_k_next;
            side_k_reg      <= side_k_next;
            left_ref_reg    <= left_ref_next;
            right_ref_reg   <= right_ref_next;
            head_ref_reg    <= head_ref_next;
            prev_right_reg  <= prev_right_next;
            prev_side_reg   <= prev_side_next;
            x_accum_reg     <= x_accum_next;
            y_accum_reg     <= y_accum_next;
            heading_now_reg <= heading_now_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cl_reg     <= cl_next;
        cr_reg     <= cr_next;
        cs_reg     <= cs_next;
        prod_reg   <= prod_next;
        dright_reg <= dright_next;
        dside_reg  <= dside_next;
        wv_reg     <= wv_next;
        theta_reg  <= theta_next;
        dth_reg    <= dth_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        z_reg      <= z_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        qmod_reg   <= qmod_next;
        qsat_reg   <= qsat_next;
        neg_reg    <= neg_next;
        sy_reg     <= sy_next;
        ratio_reg  <= ratio_next;
        t1_reg     <= t1_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("Sample accepted while an item was still in progress.");

    a_pose_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose.valid) |-> $past(state_reg == S_FINISH))
        else $error("Pose presented without a completed item.");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        (heading_now_reg >= -PI28) && (heading_now_reg < PI28))
        else $error("Heading left the wrapped range.");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FINISH) |=> ($stable(x_accum_reg) && $stable(heading_now_reg)))
        else $error("Pose state changed outside item completion.");

    a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CIT) |-> (it_reg <= IT_W'(CORDIC_STEPS - 1)))
        else $error("CORDIC iteration count ran past its end.");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Three-wheel odometry testbench
// Drives encoder samples with random gaps and register writes, predicts each
// pose with a fixed-point model of the arc odometry and compares every field.
// ----------------------------------------------------------------------------
module tb_top;
    import twodo_pkg::*;

    localparam longint P28  = 843314857;
    localparam longint TP28 = 1686629713;
    localparam longint HP30 = 1686629713;
    localparam longint P30  = 64'sd3373259426;
    localparam longint TP30 = 64'sd6746518852;
    localparam longint G30  = 652032874;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [30:0] heading;
    } pose_t;

    logic clk;
    logic rst_n;
    int   errors;
    pose_t expected_poses[$];

    twodo_cfg_if cfg_ch ();
    twodo_in_if  sample_ch ();
    twodo_out_if pose_ch ();

    three_wheel_odometry i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (sample_ch),
        .pose   (pose_ch)
    );

    longint off_l, off_r, off_s, k_wheel, k_side, ref_l, ref_r, ref_h;
    longint last_l, last_r, last_s, heading_est;
    logic [31:0] acc_x, acc_y;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint wrap_angle(longint t);
        longint m;
        m = (t + P28) % TP28;
        if (m < 0) m += TP28;
        return m - P28;
    endfunction

    function automatic longint atan_step(int i);
        longint tab[32] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
            'h00000001, 'h00000000};
        return tab[i];
    endfunction

    task automatic rotate(inout longint a, inout longint b, input longint z);
        longint t, da, db;
        if (z > HP30)
        begin
            t = a; a = -b; b = t; z -= HP30;
        end
        else if (z < -HP30)
        begin
            t = a; a = b; b = -t; z += HP30;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            da = shr(b, i);
            db = shr(a, i);
            if (z >= 0)
            begin
                a -= da; b += db; z -= atan_step(i);
            end
            else
            begin
                a += da; b -= db; z += atan_step(i);
            end
        end
    endtask

    function automatic longint travel(longint dc, longint k);
        return clamp32(shr(dc * k + 128, 8));
    endfunction

    task automatic predict_pose(input logic [31:0] cl_b, cr_b, cs_b);
        longint cl, cr, cs, s, term, theta, dth, dr, ds, dx, dy, z, p, q, r, qm;
        longint sx, sy, ratio;
        pose_t e;
        cl = $signed(cl_b); cr = $signed(cr_b); cs = $signed(cs_b);
        s = off_l + off_r;
        term = 0;
        dr = travel(cr - last_r, k_wheel);
        ds = travel(cs - last_s, k_side);
        last_l = cl; last_r = cr; last_s = cs;
        if (s != 0)
        begin
            p = k_wheel * ((cl - ref_l) - (cr - ref_r));
            q = p / s;
            r = p % s;
            if (r < 0)
            begin
                q--; r += s;
            end
            qm = q % TP28;
            if (qm < 0) qm += TP28;
            term = (qm * 1048576 + (r * 1048576) / s) % TP28;
        end
        theta = wrap_angle(term + ref_h);
        dth = wrap_angle(theta - heading_est);
        ds = clamp32(ds - shr(off_s * dth + 134217728, 28));
        if (dth == 0)
        begin
            dx = ds;
            dy = dr;
        end
        else
        begin
            sx = G30;
            sy = 0;
            rotate(sx, sy, dth * 2);
            ratio = (sy * 134217728) / dth;
            if (ratio > 536870912) ratio = 536870912;
            if (ratio < -536870912) ratio = -536870912;
            dx = clamp32(shr(ratio * ds + 134217728, 28) + shr(2 * sy * off_s + 536870912, 30));
            dy = clamp32(shr(ratio * dr + 134217728, 28) + shr(2 * sy * off_r + 536870912, 30));
        end
        z = -(heading_est * 4 + dth * 2);
        while (z >= P30) z -= TP30;
        while (z < -P30) z += TP30;
        dx = shr(dx * G30, 14);
        dy = shr(dy * G30, 14);
        rotate(dx, dy, z);
        dx = clamp32(shr(dx + 32768, 16));
        dy = clamp32(shr(dy + 32768, 16));
        heading_est = theta;
        acc_x = acc_x - dx[31:0];
        acc_y = acc_y + dy[31:0];
        e.pos_x = acc_x;
        e.pos_y = acc_y;
        e.heading = theta[30:0];
        expected_poses.push_back(e);
    endtask

    task automatic send_sample(input logic [31:0] l, r, s);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge clk);
        predict_pose(l, r, s);
        sample_ch.valid <= 1'b1;
        sample_ch.left_count <= l;
        sample_ch.right_count <= r;
        sample_ch.side_count <= s;
        do @(posedge clk); while (!sample_ch.ready);
        sample_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_poses.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_LEFT_OFFSET:  off_l = v[23:0];
            CFG_RIGHT_OFFSET: off_r = v[23:0];
            CFG_SIDE_OFFSET:  off_s = v[23:0];
            CFG_WHEEL_DIST:   k_wheel = v[23:0];
            CFG_SIDE_DIST:    k_side = v[23:0];
            CFG_LEFT_REF:     ref_l = $signed(v);
            CFG_RIGHT_REF:    ref_r = $signed(v);
            CFG_HEADING_REF:  ref_h = $signed(v[30:0]);
            default: ;
        endcase
    endtask

    task automatic test_directed();
        send_sample(0, 0, 0);
        send_sample(100, 100, 50);
        send_sample(400, 300, 60);
        send_sample(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_sample(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_sample(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000);
        send_sample(5000, -5000, 123);
        send_sample(-5000, 5000, -123);
        send_sample(-5000, 5000, -123);
        send_sample(2000, 2000, 2000);
        drain();
    endtask

    task automatic test_random_walk(input int n);
        logic [31:0] l, r, s;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                l = $urandom(); r = $urandom(); s = $urandom();
            end
            else
            begin
                l = last_l[31:0] + 32'($signed($urandom_range(0, 400)) - 200);
                r = last_r[31:0] + 32'($signed($urandom_range(0, 400)) - 200);
                s = last_s[31:0] + 32'($signed($urandom_range(0, 400)) - 200);
            end
            send_sample(l, r, s);
            if (i == n / 2) drain();
        end
        drain();
    endtask

    task automatic test_settings();
        write_reg(CFG_LEFT_OFFSET, 0);
        write_reg(CFG_RIGHT_OFFSET, 0);
        send_sample(300, 0, 10);
        send_sample(300, 0, 10);
        drain();
        write_reg(CFG_LEFT_OFFSET, 24'hFFFFFF);
        write_reg(CFG_RIGHT_OFFSET, 24'hFFFFFF);
        write_reg(CFG_SIDE_OFFSET, 24'hFFFFFF);
        write_reg(CFG_WHEEL_DIST, 24'hFFFFFF);
        write_reg(CFG_SIDE_DIST, 24'hFFFFFF);
        write_reg(CFG_LEFT_REF, 32'h7FFFFFFF);
        write_reg(CFG_RIGHT_REF, 32'h80000000);
        write_reg(CFG_HEADING_REF, 31'd843314856);
        test_random_walk(150);
        write_reg(CFG_SIDE_OFFSET, 0);
        write_reg(CFG_WHEEL_DIST, 0);
        write_reg(CFG_SIDE_DIST, 0);
        write_reg(CFG_HEADING_REF, -31'sd843314857);
        test_random_walk(60);
        write_reg(CFG_LEFT_OFFSET, 24'h020000);
        write_reg(CFG_RIGHT_OFFSET, 24'h010000);
        write_reg(CFG_SIDE_OFFSET, 24'h048000);
        write_reg(CFG_WHEEL_DIST, $urandom_range(0, 24'hFFFFFF));
        write_reg(CFG_SIDE_DIST, $urandom_range(0, 24'hFFFFFF));
        write_reg(CFG_LEFT_REF, $urandom());
        write_reg(CFG_RIGHT_REF, $urandom());
        write_reg(CFG_HEADING_REF, $urandom_range(0, 843314856));
        test_random_walk(200);
    endtask

    initial
    begin
        int gap;
        pose_ch.ready = 1'b0;
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap != 0)
            begin
                pose_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pose_ch.ready <= 1'b1;
            do @(posedge clk); while (!pose_ch.valid);
            if (expected_poses.size() == 0)
            begin
                $display("%0t: unexpected pose x=%h y=%h h=%h", $time,
                         pose_ch.pos_x, pose_ch.pos_y, pose_ch.heading);
                errors++;
            end
            else
            begin
                pose_t e;
                e = expected_poses.pop_front();
                if (pose_ch.pos_x !== e.pos_x)
                begin
                    $display("%0t: pos_x expected %h actual %h", $time, e.pos_x,
                             pose_ch.pos_x);
                    errors++;
                end
                if (pose_ch.pos_y !== e.pos_y)
                begin
                    $display("%0t: pos_y expected %h actual %h", $time, e.pos_y,
                             pose_ch.pos_y);
                    errors++;
                end
                if (pose_ch.heading !== e.heading)
                begin
                    $display("%0t: heading expected %h actual %h", $time, e.heading,
                             pose_ch.heading);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        errors = 0;
        off_l = LEFT_OFFSET_RST; off_r = RIGHT_OFFSET_RST; off_s = SIDE_OFFSET_RST;
        k_wheel = DIST_PER_DEG_RST; k_side = DIST_PER_DEG_RST;
        ref_l = 0; ref_r = 0; ref_h = 0;
        last_l = 0; last_r = 0; last_s = 0; heading_est = 0;
        acc_x = 0; acc_y = 0;
        sample_ch.valid = 1'b0;
        sample_ch.left_count = 0;
        sample_ch.right_count = 0;
        sample_ch.side_count = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_LEFT_OFFSET;
        cfg_ch.data = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_walk(900);
        test_settings();
        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
